// File: src/bitmap_frame_allocator_assert.svh
// Assertion macros shared by the frame allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BFA_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BFA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bfa_pkg.sv
// Shared constants for the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

  localparam int CNT_W       = 13;  // counts and page requests
  localparam int IDX_W       = 12;  // frame index fields
  localparam int WORD_W      = 8;   // frames per map word
  localparam int WORD_BITS_W = 3;   // log2 of WORD_W

  localparam logic [WORD_W-1:0] WORD_FULL       = 8'hFF;
  localparam logic [CNT_W-1:0]  CNT_MAX         = 13'h1FFF;
  localparam logic [CNT_W-1:0]  FRAME_COUNT_RST = 13'd4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

`default_nettype wire

// File: src/bfa_if.sv
// Request and result channel interfaces of the frame allocator.
`default_nettype none

interface bfa_in_if;
  import bfa_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [CNT_W-1:0] page_count;
  logic [IDX_W-1:0] frame_index;

  modport source (output valid, cmd, page_count, frame_index, input ready);
  modport sink   (input valid, cmd, page_count, frame_index, output ready);
endinterface

interface bfa_out_if;
  import bfa_pkg::*;

  logic             valid;
  logic             ready;
  logic             success;
  logic [IDX_W-1:0] first_frame;
  logic [CNT_W-1:0] used_total;
  logic [CNT_W-1:0] free_total;

  modport source (output valid, success, first_frame, used_total, free_total, input ready);
  modport sink   (input valid, success, first_frame, used_total, free_total, output ready);
endinterface

`default_nettype wire

// File: src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: sequencer, scan unit and counters.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   in_if    | in  | valid / ready      | cmd, page_count, frame_index
//   out_if   | out | valid / ready      | success, first_frame, used_total, free_total
//   cfg      | in  | cfg_we (no ready)  | cfg_wdata = frame_count
//
// After reset a clearing pass writes every map word to all-used, one word per cycle;
// no request transfer is taken meanwhile.
// Free: read word, write word, load result; a free out of range and an allocate that
// cannot fit by size go straight to loading the result.
// Allocate: each scan pass first issues its opening read, then the single word scanner
// takes one 8-frame map word per cycle (up to two passes for a one-frame request);
// each map word of the allocated run is then marked by read-modify-write through the
// one map port, and the result is loaded last.
// One request is in work at a time; a result waiting on out_if does not block the next
// request transfer, only the loading of that next result.

`default_nettype none

`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bfa_in_if.sink                    in_if,
  bfa_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CNT_W-1:0] cfg_wdata
);
  import bfa_pkg::*;

  localparam int WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FIW   = AW + WORD_BITS_W;
  localparam int CMPW  = (FIW > CNT_W) ? FIW : CNT_W;

  localparam logic [AW-1:0]    LAST_ADDR = AW'(WORDS - 1);
  localparam logic [CNT_W-1:0] N_CAP     = (MAX_FRAMES > int'(CNT_MAX)) ? CNT_MAX
                                                                        : CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] CNT_RST   = (FRAME_COUNT_RST > N_CAP) ? N_CAP
                                                                     : FRAME_COUNT_RST;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_FREE_RD = 8'b0000_0100,
    ST_FREE_WR = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_MARK_RD = 8'b0010_0000,
    ST_MARK_WR = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  frame_count_r, frame_count_nxt;
  logic [CNT_W-1:0]  used_cnt_r, used_cnt_nxt;
  logic [FIW-1:0]    search_start_r, search_start_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              eval_valid_r, eval_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request and working payload
  logic [CNT_W-1:0]  pages_r, pages_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              one_r, one_nxt;
  logic              pass2_r, pass2_nxt;
  logic [FIW-1:0]    lo_r, lo_nxt;
  logic [AW:0]       scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]     eval_addr_r, eval_addr_nxt;
  logic [CNT_W-1:0]  run_len_r, run_len_nxt;
  logic [FIW-1:0]    run_start_r, run_start_nxt;
  logic [CMPW-1:0]   run_last_r, run_last_nxt;
  logic [AW-1:0]     mark_addr_r, mark_addr_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [FIW-1:0]    res_first_r, res_first_nxt;

  // result register
  logic              out_success_r, out_success_nxt;
  logic [IDX_W-1:0]  out_first_r, out_first_nxt;
  logic [CNT_W-1:0]  out_used_r, out_used_nxt;
  logic [CNT_W-1:0]  out_free_r, out_free_nxt;

  // map port
  logic              map_we;
  logic [AW-1:0]     map_waddr;
  logic [WORD_W-1:0] map_wdata;
  logic              map_re;
  logic [AW-1:0]     map_raddr;
  logic [WORD_W-1:0] map_rdata;

  // derived values
  logic [CNT_W-1:0]  eff_n;
  logic [AW-1:0]     last_word;
  logic [FIW-1:0]    start_eff;
  logic [CNT_W:0]    cnt_sum;
  logic [CMPW-1:0]   next_ptr;
  logic              free_chk;

  // word scanner outputs
  logic              ev_hit;
  logic [FIW-1:0]    ev_start;
  logic [CNT_W-1:0]  ev_len;
  logic [FIW-1:0]    ev_run_start;
  logic [WORD_W-1:0] mk_mask;

  bfa_map #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Frames managed: the register limited to what the map holds.
  assign eff_n     = (frame_count_r > N_CAP) ? N_CAP : frame_count_r;
  // Only used while a search runs, where eff_n is at least one.
  assign last_word = AW'((CMPW'(eff_n) - CMPW'(1)) >> WORD_BITS_W);
  // A stale pointer restarts the next-fit search at frame zero.
  assign start_eff = (CMPW'(search_start_r) < CMPW'(eff_n)) ? search_start_r : '0;
  assign cnt_sum   = {1'b0, used_cnt_r} + {1'b0, pages_r};
  assign next_ptr  = CMPW'(res_first_r) + CMPW'(1);
  // A free that clears a used bit with a nonzero count and no register write.
  assign free_chk  = (state_r == ST_FREE_WR) && map_rdata[idx_r[WORD_BITS_W-1:0]] &&
                     (used_cnt_r != '0) && !cfg_we;

  // Scan one map word: extend or break the current free run bit by bit, stop at the
  // first bit where the run reaches the requested length. Frames below the pass's
  // lower bound or beyond the managed range count as used.
  always_comb begin : word_scan
    logic [CNT_W-1:0] len;
    logic [FIW-1:0]   st;
    logic [FIW-1:0]   f;
    logic             fr;
    len      = run_len_r;
    st       = run_start_r;
    f        = '0;
    fr       = 1'b0;
    ev_hit   = 1'b0;
    ev_start = '0;
    for (int b = 0; b < WORD_W; b++) begin
      f  = {eval_addr_r, WORD_BITS_W'(b)};
      fr = !map_rdata[b] && (f >= lo_r) && (CMPW'(f) < CMPW'(eff_n));
      if (!ev_hit) begin
        if (fr) begin
          if (len == '0) begin
            st = f;
          end
          len = len + 1'b1;
          if (len == pages_r) begin
            ev_hit   = 1'b1;
            ev_start = st;
          end
        end else begin
          len = '0;
        end
      end
    end
    ev_len       = len;
    ev_run_start = st;
  end

  // Bits of the current word that fall inside the run being marked.
  always_comb begin : run_mask
    logic [FIW-1:0] f;
    f = '0;
    for (int b = 0; b < WORD_W; b++) begin
      f          = {mark_addr_r, WORD_BITS_W'(b)};
      mk_mask[b] = (f >= res_first_r) && (CMPW'(f) <= run_last_r);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    frame_count_nxt  = frame_count_r;
    used_cnt_nxt     = used_cnt_r;
    search_start_nxt = search_start_r;
    clr_addr_nxt     = clr_addr_r;
    eval_valid_nxt   = 1'b0;
    out_valid_nxt    = out_valid_r && !out_if.ready;
    pages_nxt        = pages_r;
    idx_nxt          = idx_r;
    one_nxt          = one_r;
    pass2_nxt        = pass2_r;
    lo_nxt           = lo_r;
    scan_addr_nxt    = scan_addr_r;
    eval_addr_nxt    = eval_addr_r;
    run_len_nxt      = run_len_r;
    run_start_nxt    = run_start_r;
    run_last_nxt     = run_last_r;
    mark_addr_nxt    = mark_addr_r;
    res_ok_nxt       = res_ok_r;
    res_first_nxt    = res_first_r;
    out_success_nxt  = out_success_r;
    out_first_nxt    = out_first_r;
    out_used_nxt     = out_used_r;
    out_free_nxt     = out_free_r;
    map_we           = 1'b0;
    map_waddr        = '0;
    map_wdata        = '0;
    map_re           = 1'b0;
    map_raddr        = '0;

    // Rewriting the frame count resets the used count to the new range.
    if (cfg_we) begin
      frame_count_nxt = cfg_wdata;
      used_cnt_nxt    = (cfg_wdata > N_CAP) ? N_CAP : cfg_wdata;
    end

    unique case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr_r;
        map_wdata = WORD_FULL;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_if.valid) begin
          pages_nxt      = in_if.page_count;
          idx_nxt        = in_if.frame_index;
          one_nxt        = (in_if.page_count == CNT_W'(1));
          res_ok_nxt     = 1'b0;
          res_first_nxt  = '0;
          pass2_nxt      = 1'b0;
          run_len_nxt    = '0;
          if (in_if.cmd == CMD_FREE) begin
            state_nxt = (CMPW'(in_if.frame_index) < CMPW'(eff_n)) ? ST_FREE_RD : ST_DONE;
          end else if (in_if.page_count == '0 || in_if.page_count > eff_n) begin
            state_nxt = ST_DONE;
          end else begin
            // One frame: next-fit from the pointer; a run: first-fit from zero.
            lo_nxt        = (in_if.page_count == CNT_W'(1)) ? start_eff : '0;
            scan_addr_nxt = (in_if.page_count == CNT_W'(1))
                            ? {1'b0, start_eff[FIW-1:WORD_BITS_W]} : '0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_FREE_RD: begin
        map_re    = 1'b1;
        map_raddr = AW'(idx_r >> WORD_BITS_W);
        state_nxt = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        // Drop the used bit only if it is set; a free frame is left alone.
        if (map_rdata[idx_r[WORD_BITS_W-1:0]]) begin
          map_we       = 1'b1;
          map_waddr    = AW'(idx_r >> WORD_BITS_W);
          map_wdata    = map_rdata & ~(WORD_W'(1) << idx_r[WORD_BITS_W-1:0]);
          used_cnt_nxt = (used_cnt_r != '0) ? used_cnt_r - 1'b1 : used_cnt_r;
          res_ok_nxt   = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_SCAN: begin
        // Issue the next word read while the previous word is evaluated.
        if (scan_addr_r <= {1'b0, last_word}) begin
          map_re         = 1'b1;
          map_raddr      = scan_addr_r[AW-1:0];
          eval_valid_nxt = 1'b1;
          eval_addr_nxt  = scan_addr_r[AW-1:0];
          scan_addr_nxt  = scan_addr_r + 1'b1;
        end
        if (eval_valid_r) begin
          if (ev_hit) begin
            res_ok_nxt     = 1'b1;
            res_first_nxt  = ev_start;
            run_last_nxt   = CMPW'(ev_start) + CMPW'(pages_r) - CMPW'(1);
            mark_addr_nxt  = ev_start[FIW-1:WORD_BITS_W];
            eval_valid_nxt = 1'b0;
            state_nxt      = ST_MARK_RD;
          end else if (eval_addr_r == last_word) begin
            eval_valid_nxt = 1'b0;
            if (one_r && !pass2_r && lo_r != '0) begin
              // Wrap once: rescan from frame zero.
              pass2_nxt     = 1'b1;
              lo_nxt        = '0;
              scan_addr_nxt = '0;
              run_len_nxt   = '0;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            run_len_nxt   = ev_len;
            run_start_nxt = ev_run_start;
          end
        end
      end

      ST_MARK_RD: begin
        map_re    = 1'b1;
        map_raddr = mark_addr_r;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        map_we    = 1'b1;
        map_waddr = mark_addr_r;
        map_wdata = map_rdata | mk_mask;
        if (mark_addr_r == AW'(run_last_r >> WORD_BITS_W)) begin
          used_cnt_nxt = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
          if (one_r) begin
            search_start_nxt = (next_ptr >= CMPW'(eff_n)) ? '0 : FIW'(next_ptr);
          end
          state_nxt = ST_DONE;
        end else begin
          mark_addr_nxt = mark_addr_r + 1'b1;
          state_nxt     = ST_MARK_RD;
        end
      end

      ST_DONE: begin
        // Hold here until the result register is free for the next transfer.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = res_ok_r;
          out_first_nxt   = res_ok_r ? IDX_W'(res_first_r) : '0;
          out_used_nxt    = used_cnt_r;
          out_free_nxt    = (used_cnt_r < eff_n) ? eff_n - used_cnt_r : '0;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      frame_count_r  <= FRAME_COUNT_RST;
      used_cnt_r     <= CNT_RST;
      search_start_r <= '0;
      clr_addr_r     <= '0;
      eval_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_count_r  <= frame_count_nxt;
      used_cnt_r     <= used_cnt_nxt;
      search_start_r <= search_start_nxt;
      clr_addr_r     <= clr_addr_nxt;
      eval_valid_r   <= eval_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pages_r       <= pages_nxt;
    idx_r         <= idx_nxt;
    one_r         <= one_nxt;
    pass2_r       <= pass2_nxt;
    lo_r          <= lo_nxt;
    scan_addr_r   <= scan_addr_nxt;
    eval_addr_r   <= eval_addr_nxt;
    run_len_r     <= run_len_nxt;
    run_start_r   <= run_start_nxt;
    run_last_r    <= run_last_nxt;
    mark_addr_r   <= mark_addr_nxt;
    res_ok_r      <= res_ok_nxt;
    res_first_r   <= res_first_nxt;
    out_success_r <= out_success_nxt;
    out_first_r   <= out_first_nxt;
    out_used_r    <= out_used_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.success     = out_success_r;
  assign out_if.first_frame = out_first_r;
  assign out_if.used_total  = out_used_r;
  assign out_if.free_total  = out_free_r;

  // The scanner only reads the map.
  `BFA_CHK(a_no_write_in_scan, state_r == ST_SCAN, !map_we, "map written during scan")

  // A found run lies wholly inside the managed range.
  `BFA_CHK(a_run_in_range, state_r == ST_MARK_RD, run_last_r < CMPW'(eff_n), "run out of range")

  // A successful free lowers the used count by exactly one.
  `BFA_CHK_NEXT(a_free_dec, free_chk, used_cnt_r == $past(used_cnt_r) - 1'b1, "count not lowered")

  // A new result appears only from the result-load state.
  `BFA_CHK(a_result_src, $rose(out_valid_r), $past(state_r == ST_DONE), "result without request")

endmodule

`default_nettype wire

// File: src/bfa_map.sv
// Used-frame map storage: one write port, one registered read port.
`default_nettype none

module bfa_map #(
  parameter int WORDS = 512,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bfa_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bfa_pkg::WORD_W-1:0] rdata
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: verif/bfa_scoreboard_pkg.sv
// Scoreboard class that tracks the frame map and checks allocator results.
package bfa_scoreboard_pkg;
  import bfa_pkg::*;

  localparam int MAP_DEPTH = 4096;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] first_frame;
    logic [CNT_W-1:0] used_total;
    logic [CNT_W-1:0] free_total;
  } alloc_result_t;

  class alloc_scoreboard;
    bit               used_map [MAP_DEPTH];
    logic [CNT_W-1:0] frame_count;
    int unsigned      used_count;
    int unsigned      next_fit_ptr;
    alloc_result_t    awaited_results [$];
    int unsigned      results_seen;
    int unsigned      mismatches;

    function new();
      foreach (used_map[f]) used_map[f] = 1'b1;
      frame_count  = FRAME_COUNT_RST;
      used_count   = managed_frames();
      next_fit_ptr = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function int unsigned managed_frames();
      return (frame_count > MAP_DEPTH) ? MAP_DEPTH : int'(frame_count);
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    function void write_frame_count(logic [CNT_W-1:0] value);
      frame_count = value;
      used_count  = managed_frames();
    endfunction

    function void bump_used();
      if (used_count < CNT_MAX) used_count++;
    endfunction

    // Next-fit from the rotating pointer, one wrap to frame zero.
    function bit take_single(int unsigned n, output int unsigned first);
      int unsigned start;
      int unsigned f;
      first = 0;
      start = (next_fit_ptr < n) ? next_fit_ptr : 0;
      for (int unsigned k = 0; k < n; k++) begin
        f = start + k;
        if (f >= n) f -= n;
        if (!used_map[f]) begin
          used_map[f]  = 1'b1;
          bump_used();
          next_fit_ptr = (f + 1 >= n) ? 0 : f + 1;
          first        = f;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // First-fit contiguous run from frame zero; the pointer stays put.
    function bit take_run(int unsigned n, int unsigned pages, output int unsigned first);
      int unsigned i;
      int unsigned j;
      bit          run_free;
      first = 0;
      i     = 0;
      if (pages > n) return 1'b0;
      while (i + pages <= n) begin
        run_free = 1'b1;
        for (j = 0; j < pages; j++) begin
          if (used_map[i + j]) begin
            run_free = 1'b0;
            break;
          end
        end
        if (run_free) begin
          for (j = 0; j < pages; j++) begin
            used_map[i + j] = 1'b1;
            bump_used();
          end
          first = i;
          return 1'b1;
        end
        i += j + 1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic cmd, logic [CNT_W-1:0] pages, logic [IDX_W-1:0] idx);
      int unsigned   n;
      int unsigned   first;
      bit            ok;
      alloc_result_t want;
      n     = managed_frames();
      first = 0;
      ok    = 1'b0;
      if (cmd == CMD_ALLOC) begin
        if (pages == 1) ok = take_single(n, first);
        else if (pages > 1) ok = take_run(n, int'(pages), first);
        if (!ok) first = 0;
      end else if (idx < n && used_map[idx]) begin
        used_map[idx] = 1'b0;
        if (used_count > 0) used_count--;
        ok = 1'b1;
      end
      want.success     = ok;
      want.first_frame = IDX_W'(first);
      want.used_total  = CNT_W'(used_count);
      want.free_total  = (used_count < n) ? CNT_W'(n - used_count) : CNT_W'(0);
      awaited_results.push_back(want);
    endfunction

    function void check_result(logic success, logic [IDX_W-1:0] first_frame,
                               logic [CNT_W-1:0] used_total, logic [CNT_W-1:0] free_total);
      alloc_result_t want;
      string         head;
      results_seen++;
      if (awaited_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("result %0d: unexpected, success %0b first_frame %0d used %0d free %0d",
                   results_seen, success, first_frame, used_total, free_total);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (success !== want.success || first_frame !== want.first_frame ||
          used_total !== want.used_total || free_total !== want.free_total) begin
        if (mismatches < REPORT_MAX) begin
          head = $sformatf("result %0d mismatch (expected/actual): success %0b/%0b",
                           results_seen, want.success, success);
          $display("%s first_frame %0d/%0d used_total %0d/%0d free_total %0d/%0d",
                   head, want.first_frame, first_frame, want.used_total, used_total,
                   want.free_total, free_total);
        end
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: verif/bitmap_frame_allocator_tb.sv
// Top-level testbench of the bitmap frame allocator.
module bitmap_frame_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;
  import bfa_scoreboard_pkg::*;

  // Cycle budget for the whole run; a correct run stays well inside it.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned IDLE_HOLDOFF = 4;
  localparam int unsigned END_HOLDOFF  = 32;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_TRICKLE,
    SINK_PERIODIC
  } sink_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  bfa_in_if  req_ch ();
  bfa_out_if result_ch ();

  alloc_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     burst_left  = 0;

  bitmap_frame_allocator #(
    .MAX_FRAMES(MAP_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (req_ch),
    .out_if   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample both channels at the rising edge: check the result transfer against the
  // oldest expectation, then predict the request transfer taken at the same edge.
  // Bail out if the run exceeds the cycle budget.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.success, result_ch.first_frame,
                        result_ch.used_total, result_ch.free_total);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.cmd, req_ch.page_count, req_ch.frame_index);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: hold ready on a changing pattern, switching to a random mode after each
  // random span so stalls land on every phase of the block's work.
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned span;
    int unsigned tick;
    tick            = 0;
    result_ch.ready = 1'b0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          SINK_OPEN: begin
            result_ch.ready <= 1'b1;
          end
          SINK_COIN: begin
            result_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          SINK_TRICKLE: begin
            result_ch.ready <= (tick % 7 == 0);
          end
          default: begin
            result_ch.ready <= (tick % 4 != 3);
          end
        endcase
      end
    end
  end

  // Drive one request and hold it until the transfer. Between bursts drop valid
  // for a random gap; a zero gap keeps valid high back to back. Called and left at
  // a falling edge.
  task automatic send_request(input logic cmd, input logic [CNT_W-1:0] pages,
                              input logic [IDX_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= cmd;
    req_ch.page_count  <= pages;
    req_ch.frame_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Drop valid and wait for every expected result, then let the block settle.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left   = 0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (IDLE_HOLDOFF) @(negedge clk);
  endtask

  // Write the frame count register; only called with the block idle.
  task automatic write_frame_count(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_frame_count(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random request. Frees mostly target the managed range plus a frame or two
  // past it; allocations are mostly single frames and short runs. Unused fields
  // carry random junk.
  task automatic random_request(input int unsigned free_pct);
    int unsigned n;
    int unsigned r;
    int unsigned hi;
    int unsigned cap;
    logic [CNT_W-1:0] pages;
    logic [IDX_W-1:0] idx;
    n     = sb.managed_frames();
    r     = $urandom_range(0, 99);
    pages = CNT_W'($urandom_range(0, 8191));
    idx   = IDX_W'($urandom_range(0, 4095));
    if (r < free_pct) begin
      if ($urandom_range(0, 9) != 0) begin
        hi  = (n + 1 > 4095) ? 4095 : n + 1;
        idx = IDX_W'($urandom_range(0, hi));
      end
      send_request(CMD_FREE, pages, idx);
    end else if (r < free_pct + (100 - free_pct) * 6 / 10) begin
      send_request(CMD_ALLOC, CNT_W'(1), idx);
    end else if (r < 96) begin
      cap = (n < 24) ? n : 24;
      if ($urandom_range(0, 4) == 0) cap = n;
      if (cap < 2) cap = 2;
      send_request(CMD_ALLOC, CNT_W'($urandom_range(2, cap)), idx);
    end else begin
      case ($urandom_range(0, 2))
        0: pages = CNT_W'(0);
        1: pages = CNT_W'(n + 1);
        default: pages = CNT_W'($urandom_range(0, 8191));
      endcase
      send_request(CMD_ALLOC, pages, idx);
    end
  endtask

  // Reprogram the frame count, then run a random mix with a full drain halfway.
  task automatic run_phase(input logic [CNT_W-1:0] frames, input int unsigned items,
                           input int unsigned free_pct);
    drain_results();
    write_frame_count(frames);
    for (int unsigned i = 0; i < items; i++) begin
      if (i == items / 2) drain_results();
      random_request(free_pct);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_frames [11];
    int unsigned phase_items [11];
    int unsigned phase_free_pct [11];
    sb = new();

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_ALLOC;
    req_ch.page_count  = '0;
    req_ch.frame_index = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset map has every frame used at the default count.
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // nothing free
    send_request(CMD_ALLOC, CNT_W'(0), IDX_W'(4095));     // zero pages
    send_request(CMD_ALLOC, CNT_W'(8191), IDX_W'(0));     // more pages than frames
    send_request(CMD_ALLOC, CNT_W'(4096), IDX_W'(0));     // whole map, all used
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(0));         // frame zero
    send_request(CMD_FREE, CNT_W'(8191), IDX_W'(4095));   // last frame
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(0));         // already free
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // takes frame zero
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // last frame, pointer wraps
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(4094));
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(4095));
    send_request(CMD_ALLOC, CNT_W'(2), IDX_W'(0));        // run ending on the last frame
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(3000));
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // moves the pointer high
    drain_results();
    write_frame_count(CNT_W'(16));                       // pointer now stale
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(5));
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(20));        // out of range
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // restarts at frame zero
    send_request(CMD_ALLOC, CNT_W'(17), IDX_W'(0));       // longer than the range
    drain_results();
    write_frame_count(CNT_W'(0));                        // no frames managed
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(0));
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));
    drain_results();
    write_frame_count(CNT_W'(8191));                     // clamps to the map size
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(1));
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));        // wraps to find frame one

    // Random phases; the large maps get few items since every scan is long.
    phase_frames   = '{1, 8, 2, 37, 64, 4096, 9, 100, 4095, 0, 0};
    phase_items    = '{60, 150, 60, 250, 300, 80, 150, 300, 60, 200, 60};
    phase_free_pct = '{50, 45, 50, 40, 45, 30, 50, 45, 40, 45, 40};
    phase_frames[9]  = $urandom_range(3, 200);
    phase_frames[10] = $urandom_range(0, 8191);
    for (int p = 0; p < 11; p++)
      run_phase(CNT_W'(phase_frames[p]), phase_items[p], phase_free_pct[p]);

    // Used count above the frames in use: free a block of frames, reprogram so the
    // count is full again, then take the block back in one run.
    drain_results();
    write_frame_count(CNT_W'(4096));
    for (int unsigned f = 0; f < 64; f++)
      send_request(CMD_FREE, CNT_W'($urandom_range(0, 8191)), IDX_W'(f));
    drain_results();
    write_frame_count(CNT_W'(4096));
    send_request(CMD_ALLOC, CNT_W'(64), IDX_W'(0));
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(7));
    send_request(CMD_FREE, CNT_W'(0), IDX_W'(4095));
    send_request(CMD_ALLOC, CNT_W'(1), IDX_W'(0));
    send_request(CMD_ALLOC, CNT_W'(3), IDX_W'(0));

    run_phase(CNT_W'(24), 150, 50);
    run_phase(CNT_W'(5), 80, 50);

    // Wait out the last results, then a settle window.
    drain_results();
    repeat (END_HOLDOFF) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: bitmap_frame_allocator.f
+incdir+src
src/bfa_pkg.sv
src/bfa_if.sv
src/bfa_map.sv
src/bitmap_frame_allocator.sv
verif/bfa_scoreboard_pkg.sv
verif/bitmap_frame_allocator_tb.sv
